// File: hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SIL_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define SIL_ASSERT(label, prop, msg) \
  `SIL_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: hdl/sil_pkg.sv
package sil_pkg;

  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned VALUE_W    = 32;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DUMP   = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_ELEMENT  = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DUMP
  } state_e;

  typedef struct packed {
    action_e                    action;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  item_value;
    status_e                    status;
    logic                       last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    insert;
    logic    rotate;
    logic    idx_clr;
    logic    emit;
    status_e emit_status;
    logic    emit_last;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_dump;
    logic full;
    logic empty;
    logic idx_last;
  } stat_t;

endpackage

// File: hdl/sil_ctrl.sv
module sil_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sil_pkg::stat_t  stat_i,
  output sil_pkg::ctrl_t  ctrl_o,
  output logic            busy_o
);

  sil_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sil_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    ctrl_o             = '0;
    ctrl_o.emit_status = sil_pkg::STAT_INSERTED;
    busy_o             = 1'b1;
    case (state_q)
      sil_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = sil_pkg::S_EXEC;
        end
      end
      sil_pkg::S_EXEC: begin
        if (!stat_i.is_dump) begin
          ctrl_o.emit      = 1'b1;
          ctrl_o.emit_last = 1'b1;
          if (stat_i.full) begin
            ctrl_o.emit_status = sil_pkg::STAT_FULL;
          end else begin
            ctrl_o.insert      = 1'b1;
            ctrl_o.emit_status = sil_pkg::STAT_INSERTED;
          end
          state_d = sil_pkg::S_IDLE;
        end else if (stat_i.empty) begin
          ctrl_o.emit        = 1'b1;
          ctrl_o.emit_last   = 1'b1;
          ctrl_o.emit_status = sil_pkg::STAT_EMPTY;
          state_d            = sil_pkg::S_IDLE;
        end else begin
          ctrl_o.idx_clr = 1'b1;
          state_d        = sil_pkg::S_DUMP;
        end
      end
      sil_pkg::S_DUMP: begin
        // The head entry is emitted while the list rotates by one place.
        ctrl_o.emit        = 1'b1;
        ctrl_o.emit_status = sil_pkg::STAT_ELEMENT;
        ctrl_o.emit_last   = stat_i.idx_last;
        ctrl_o.rotate      = 1'b1;
        if (stat_i.idx_last) begin
          state_d = sil_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sil_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/sil_datapath.sv
module sil_datapath #(
  parameter int unsigned DEPTH = sil_pkg::LIST_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sil_pkg::cmd_t     cmd_i,
  input  sil_pkg::ctrl_t    ctrl_i,
  output sil_pkg::stat_t    stat_o,
  output logic              result_valid_o,
  output sil_pkg::result_t  result_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sil_pkg::cmd_t                     op_q;
  logic signed [sil_pkg::VALUE_W-1:0] cell_q [DEPTH];
  logic signed [sil_pkg::VALUE_W-1:0] cell_d [DEPTH];
  logic [DEPTH-1:0]                  le;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [CNT_W-1:0]                  idx_q, idx_d;
  logic                              valid_q;
  sil_pkg::result_t                  result_q, result_d;

  // Each cell compares itself with the operand; the set of cells that are
  // less than or equal forms a prefix because the list is kept sorted.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign le[i] = (CNT_W'(i) < count_q) && (cell_q[i] <= op_q.value);

    if (i == 0) begin : g_head
      always_comb begin
        cell_d[i] = cell_q[i];
        if (ctrl_i.insert) begin
          cell_d[i] = le[i] ? cell_q[i] : op_q.value;
        end else if (ctrl_i.rotate) begin
          cell_d[i] = (count_q == CNT_W'(1)) ? cell_q[0] : cell_q[1 % DEPTH];
        end
      end
    end else begin : g_body
      always_comb begin
        cell_d[i] = cell_q[i];
        if (ctrl_i.insert) begin
          if (le[i]) begin
            cell_d[i] = cell_q[i];
          end else if (le[i-1]) begin
            cell_d[i] = op_q.value;
          end else begin
            cell_d[i] = cell_q[i-1];
          end
        end else if (ctrl_i.rotate) begin
          if (CNT_W'(i + 1) == count_q || i == DEPTH - 1) begin
            cell_d[i] = cell_q[0];
          end else begin
            cell_d[i] = cell_q[(i + 1) % DEPTH];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_q[i] <= cell_d[i];
    end
    if (ctrl_i.load) begin
      op_q <= cmd_i;
    end
    result_q <= result_d;
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.insert) begin
      count_d = count_q + CNT_W'(1);
    end
    idx_d = idx_q;
    if (ctrl_i.idx_clr) begin
      idx_d = '0;
    end else if (ctrl_i.rotate) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_comb begin
    result_d.status     = ctrl_i.emit_status;
    result_d.last       = ctrl_i.emit_last;
    result_d.item_value = (ctrl_i.emit_status == sil_pkg::STAT_ELEMENT) ? cell_q[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      valid_q <= ctrl_i.emit;
    end
  end

  assign stat_o.is_dump  = (op_q.action == sil_pkg::ACT_DUMP);
  assign stat_o.full     = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.idx_last = ((idx_q + CNT_W'(1)) == count_q);

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

// File: hdl/sorted_insert_list.sv
// Sorted list of signed 32-bit values held in a row of DEPTH register cells.
// Raise start_i with a command while busy_o is low; that cycle is the
// transfer. An insert passes S_EXEC: every cell compares itself with the
// new value in parallel and the list shifts open in one step, so a new
// command can follow as soon as busy_o drops. The single status result
// (inserted, or dropped because the list is full) appears on result_o for
// one cycle with result_valid_o. A dump of N stored values passes S_EXEC,
// then S_DUMP: the head cell streams out one value per cycle while the list
// rotates, ending in its original order; the final value carries last.
// A dump of an empty list gives one empty result. Results cannot be
// stalled: the receiver must take each one in the cycle it is shown.
module sorted_insert_list #(
  parameter int unsigned DEPTH = sil_pkg::LIST_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sil_pkg::cmd_t     cmd_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output sil_pkg::result_t  result_o
);

  sil_pkg::ctrl_t ctrl;
  sil_pkg::stat_t stat;

  sil_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  sil_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// File: hdl/sil_checker.sv
`include "assert_macros.svh"

module sil_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input sil_pkg::result_t  result_o
);

  logic is_element;

  assign is_element = (result_o.status == sil_pkg::STAT_ELEMENT);

  // A transfer always keeps the block busy in the following cycle.
  `SIL_ASSERT(a_busy_after_start, (start_i && !busy_o) |=> busy_o, "not busy after a transfer")

  // Only list elements carry a value; every other result is the only one.
  `SIL_ASSERT(a_zero_value, (result_valid_o && !is_element) |-> (result_o.item_value == '0), "nonzero value on a status result")
  `SIL_ASSERT(a_status_last, (result_valid_o && !is_element) |-> result_o.last, "status result without last")

  // A dump still streaming keeps the block busy, and a final result is never
  // followed directly by another.
  `SIL_ASSERT(a_busy_in_dump, (result_valid_o && !result_o.last) |-> busy_o, "idle while a dump is streaming")
  `SIL_ASSERT(a_gap_after_last, (result_valid_o && result_o.last) |=> !result_valid_o, "result right after a final result")

endmodule

bind sorted_insert_list sil_checker u_sil_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
